FILE: hdl/sub_pkg.sv
// ----------------------------------------------------------------------------
// sub_pkg
// Shared types and codes for the three-channel UART to SPI frame bridge.
// ----------------------------------------------------------------------------
`default_nettype none

package sub_pkg;

  localparam int NUM_CHAN = 3;

  // input event codes
  localparam logic [1:0] IN_UART_BYTE = 2'd0;
  localparam logic [1:0] IN_SPI_BYTE  = 2'd1;
  localparam logic [1:0] IN_BOUNDARY  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SPI_TX  = 2'd0;
  localparam logic [1:0] KIND_UART_TX = 2'd1;
  localparam logic [1:0] KIND_BAUD    = 2'd2;

  // SPI frame command bytes (base + channel)
  localparam logic [7:0] CMD_TX_BASE  = 8'h11;
  localparam logic [7:0] CMD_TX_TOP   = 8'h13;
  localparam logic [7:0] CMD_CFG_BASE = 8'h21;
  localparam logic [7:0] CMD_CFG_TOP  = 8'h23;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_DATA
  } sub_state_t;

endpackage

`default_nettype wire

FILE: hdl/spi_uart_bridge_framer.sv
// ----------------------------------------------------------------------------
// spi_uart_bridge_framer
// Queues bytes from three UARTs and sends them in fixed-length SPI frames,
// picked round-robin; parses incoming SPI frames into UART bytes and baud
// settings.
// ----------------------------------------------------------------------------
//  channel | direction | beat carries
//  --------+-----------+----------------------------------------------------
//  in_     | input     | cmd, channel, data_byte
//  out_    | output    | kind, out_channel, out_byte, baud_rate, last
//
//  UART and SPI byte events are accepted while idle; an SPI byte that yields a
//  result loads the output register in the same cycle.
//  A frame boundary sends FRAME_BYTES output bytes, n of them queued data
//  bytes (at most FRAME_BYTES-2): each data byte is fetched through a
//  registered read of the shared queue RAM, in ST_FRAME and then ST_DATA.
//  Input is stalled while a frame is going out and whenever the output
//  register is full and stalled. Reset is synchronous; the queue RAM and
//  outgoing-frame registers are not cleared; counts, pointers and state are.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_uart_bridge_framer #(
  parameter int FRAME_BYTES = 32,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [1:0]  in_channel,
  input  wire logic [7:0]  in_data_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [1:0]       out_channel,
  output logic [7:0]       out_byte,
  output logic [31:0]      out_baud_rate,
  output logic             out_last
);

  import sub_pkg::*;

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CHAN * QUEUE_DEPTH;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int PW = $clog2(FRAME_BYTES + 1);
  localparam int NW = $clog2(FRAME_BYTES - 1);
  localparam int MAX_N = FRAME_BYTES - 2;
  localparam bit FB_IS_4 = (FRAME_BYTES == 4);

  // state
  sub_state_t      state_r, state_nxt;
  logic [HW-1:0]   head_r [NUM_CHAN];
  logic [HW-1:0]   head_nxt [NUM_CHAN];
  logic [CW-1:0]   cnt_r [NUM_CHAN];
  logic [CW-1:0]   cnt_nxt [NUM_CHAN];
  logic [1:0]      turn_r, turn_nxt;
  logic [PW-1:0]   rxpos_r, rxpos_nxt;
  logic [7:0]      rxcmd_r, rxcmd_nxt;
  logic [7:0]      rxlen_r, rxlen_nxt;
  logic [23:0]     baud_r, baud_nxt;

  // outgoing frame
  logic [1:0]      fch_r, fch_nxt;
  logic            factive_r, factive_nxt;
  logic [NW-1:0]   flen_r, flen_nxt;
  logic [PW-1:0]   fpos_r, fpos_nxt;

  // queue RAM
  logic [7:0]      mem_r [MEM_DEPTH];
  logic [7:0]      rdata_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_addr;
  logic [7:0]      mem_wdata;

  // output register
  logic            out_valid_r;
  logic [1:0]      kind_r, kind_nxt;
  logic [1:0]      och_r, och_nxt;
  logic [7:0]      obyte_r, obyte_nxt;
  logic [31:0]     obaud_r, obaud_nxt;
  logic            olast_r, olast_nxt;
  logic            out_load;

  logic            out_free, acc;
  logic            is_data, last_pos;
  logic [1:0]      sel_ch;
  logic [HW-1:0]   sel_head;
  logic [CW-1:0]   sel_cnt;
  logic [AW-1:0]   base_addr;
  logic [HW:0]     tail_sum;
  logic [HW-1:0]   tail_slot;
  logic [HW-1:0]   head_inc;
  logic [7:0]      len_eff;
  logic [PW:0]     data_end;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign acc       = in_valid && !in_stall;

  assign data_end  = (PW+1)'(flen_r) + (PW+1)'(2);
  assign is_data   = factive_r && (fpos_r >= PW'(2)) && ((PW+1)'(fpos_r) < data_end);
  assign last_pos  = (fpos_r == PW'(FRAME_BYTES - 1));

  // one queue is touched per cycle
  always_comb begin
    if (state_r != ST_IDLE) begin
      sel_ch = fch_r;
    end else if (in_cmd == IN_BOUNDARY) begin
      sel_ch = turn_r;
    end else begin
      sel_ch = in_channel;
    end
  end

  assign sel_head = (sel_ch < 2'(NUM_CHAN)) ? head_r[sel_ch] : '0;
  assign sel_cnt  = (sel_ch < 2'(NUM_CHAN)) ? cnt_r[sel_ch]  : '0;

  always_comb begin
    case (sel_ch)
      2'd0:    base_addr = '0;
      2'd1:    base_addr = AW'(QUEUE_DEPTH);
      default: base_addr = AW'(2 * QUEUE_DEPTH);
    endcase
  end

  assign tail_sum  = (HW+1)'(sel_head) + (HW+1)'(sel_cnt);
  assign tail_slot = (tail_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                     HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign head_inc  = (sel_head == HW'(QUEUE_DEPTH - 1)) ? '0 : sel_head + HW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_cmd == IN_BOUNDARY) state_nxt = ST_FRAME;
      end
      ST_FRAME: begin
        if (out_free) begin
          if (is_data) begin
            state_nxt = ST_DATA;
          end else if (last_pos) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        state_nxt = last_pos ? ST_IDLE : ST_FRAME;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    turn_nxt    = turn_r;
    rxpos_nxt   = rxpos_r;
    rxcmd_nxt   = rxcmd_r;
    rxlen_nxt   = rxlen_r;
    baud_nxt    = baud_r;
    fch_nxt     = fch_r;
    factive_nxt = factive_r;
    flen_nxt    = flen_r;
    fpos_nxt    = fpos_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = base_addr + AW'(sel_head);
    mem_wdata   = in_data_byte;
    out_load    = 1'b0;
    kind_nxt    = KIND_SPI_TX;
    och_nxt     = 2'd0;
    obyte_nxt   = 8'd0;
    obaud_nxt   = 32'd0;
    olast_nxt   = 1'b0;
    len_eff     = (rxpos_r == PW'(1)) ? in_data_byte : rxlen_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_cmd)
            IN_UART_BYTE: begin
              if (in_channel < 2'(NUM_CHAN) && sel_cnt < CW'(QUEUE_DEPTH)) begin
                mem_we            = 1'b1;
                mem_addr          = base_addr + AW'(tail_slot);
                cnt_nxt[sel_ch]   = sel_cnt + CW'(1);
              end
            end
            IN_SPI_BYTE: begin
              if (rxpos_r < PW'(FRAME_BYTES)) begin
                rxpos_nxt = rxpos_r + PW'(1);
                if (rxpos_r == '0) begin
                  rxcmd_nxt = in_data_byte;
                end else begin
                  if (rxpos_r == PW'(1)) rxlen_nxt = in_data_byte;
                  if (rxcmd_r inside {[CMD_TX_BASE:CMD_TX_TOP]}) begin
                    if (rxpos_r >= PW'(2) && 32'(len_eff) <= FRAME_BYTES &&
                        32'(rxpos_r) - 32'd2 < 32'(len_eff)) begin
                      out_load  = 1'b1;
                      kind_nxt  = KIND_UART_TX;
                      och_nxt   = 2'(rxcmd_r - CMD_TX_BASE);
                      obyte_nxt = in_data_byte;
                    end
                  end else if (rxcmd_r inside {[CMD_CFG_BASE:CMD_CFG_TOP]}) begin
                    case (rxpos_r)
                      PW'(1):  baud_nxt[7:0]   = in_data_byte;
                      PW'(2):  baud_nxt[15:8]  = in_data_byte;
                      PW'(3):  baud_nxt[23:16] = in_data_byte;
                      default: baud_nxt        = baud_r;
                    endcase
                    if (rxpos_r == PW'(4)) begin
                      out_load  = 1'b1;
                      kind_nxt  = KIND_BAUD;
                      och_nxt   = 2'(rxcmd_r - CMD_CFG_BASE);
                      obaud_nxt = {in_data_byte, baud_r};
                    end else if (FB_IS_4 && rxpos_r == PW'(3)) begin
                      // byte 4 falls outside a 4-byte frame and counts as zero
                      out_load  = 1'b1;
                      kind_nxt  = KIND_BAUD;
                      och_nxt   = 2'(rxcmd_r - CMD_CFG_BASE);
                      obaud_nxt = {8'd0, in_data_byte, baud_r[15:0]};
                    end
                  end
                end
              end
            end
            IN_BOUNDARY: begin
              fch_nxt     = turn_r;
              factive_nxt = (sel_cnt != '0);
              flen_nxt    = (32'(sel_cnt) > MAX_N) ? NW'(MAX_N) : NW'(sel_cnt);
              fpos_nxt    = '0;
              turn_nxt    = (turn_r == 2'(NUM_CHAN - 1)) ? 2'd0 : turn_r + 2'd1;
              rxpos_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FRAME: begin
        if (out_free) begin
          if (is_data) begin
            mem_re = 1'b1;
          end else begin
            out_load  = 1'b1;
            olast_nxt = last_pos;
            fpos_nxt  = fpos_r + PW'(1);
            if (fpos_r == '0 && factive_r) begin
              obyte_nxt = CMD_TX_BASE + 8'(fch_r);
            end else if (fpos_r == PW'(1)) begin
              obyte_nxt = 8'(flen_r);
            end
          end
        end
      end
      ST_DATA: begin
        // output register is empty here: the FRAME cycle found it free
        out_load        = 1'b1;
        obyte_nxt       = rdata_r;
        olast_nxt       = last_pos;
        fpos_nxt        = fpos_r + PW'(1);
        head_nxt[sel_ch] = head_inc;
        cnt_nxt[sel_ch]  = sel_cnt - CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      turn_r      <= 2'd0;
      rxpos_r     <= '0;
      rxcmd_r     <= 8'd0;
      rxlen_r     <= 8'd0;
      baud_r      <= 24'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHAN; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      turn_r    <= turn_nxt;
      rxpos_r   <= rxpos_nxt;
      rxcmd_r   <= rxcmd_nxt;
      rxlen_r   <= rxlen_nxt;
      baud_r    <= baud_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fch_r     <= fch_nxt;
    factive_r <= factive_nxt;
    flen_r    <= flen_nxt;
    fpos_r    <= fpos_nxt;
    if (out_load) begin
      kind_r  <= kind_nxt;
      och_r   <= och_nxt;
      obyte_r <= obyte_nxt;
      obaud_r <= obaud_nxt;
      olast_r <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem_r[mem_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_channel   = och_r;
  assign out_byte      = obyte_r;
  assign out_baud_rate = obaud_r;
  assign out_last      = olast_r;

endmodule

`default_nettype wire
